FILE: sv/assert_macros.svh
// Assertion macros for the tracker RTL.
// Included by lpht_ctrl, which carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Condition checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Condition that must hold whenever the guard is high.
`define ASSERT_WHEN(label, clk, rst_n, guard, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (guard) |-> (cond)) \
		else $error(msg);
`endif

FILE: sv/lpht_pkg.sv
// Shared types, constants and the hash function of the tracker.
// No dependencies.
`timescale 1ns / 1ps
package lpht_pkg;
	localparam int TableBitsDefault = 10;
	localparam int KeyW = 32;
	localparam int FileW = 32;
	localparam int LineW = 20;
	localparam int BytesW = 32;
	localparam int EntryW = KeyW + FileW + LineW + BytesW;
	localparam int StatusW = 3;
	localparam int LiveW = 10;
	localparam logic [31:0] HashXor = 32'hdeadbeef;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_DUP = 3'd1, ST_MISSING = 3'd2, ST_FULL = 3'd3, ST_ZERO = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_PRD, S_PCHK, S_SRD, S_SCHK, S_SMOVE, S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;     // capture input word, start probe at home slot
		logic rd;       // read slot at probe index
		logic adv;      // step probe index
		logic ins;      // write captured entry at probe index
		logic clr_hole; // clear valid of hole
		logic move;     // copy read entry into hole, hole := probe index
		logic start_shift; // hole := probe index, probe index += 1
		logic clr_step; // clearing sweep step
		logic inc;
		logic dec;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic slot_valid;
		logic key_match;
		logic may_shift;
		logic zero_key;
		logic is_remove;
		logic full;
		logic clr_done;
	} sts_t;

	function automatic logic [31:0] hash32(input logic [31:0] k);
		logic [31:0] a;
		a = k ^ (k >> 4);
		a = (a ^ HashXor) + (a << 5);
		a = a ^ (a >> 11);
		return a;
	endfunction
endpackage

FILE: sv/linear_probe_hash_tracker.sv
// Top level of the allocation tracker hash table.
// Depends on lpht_pkg, lpht_ctrl, lpht_datapath.
`timescale 1ns / 1ps
// Linear-probing hash table of live allocations keyed by 32-bit pointer,
// with backward-shift delete. After reset a clearing sweep of all 2^TABLE_BITS
// slots runs before the first word is taken. One word is handled at a time
// through a single-port slot RAM: each probed slot is read and then checked,
// and a remove then walks the following cluster, shifting entries back into
// the hole, before the result is offered.
module linear_probe_hash_tracker #(
	parameter int TABLE_BITS = lpht_pkg::TableBitsDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// opcode[0], lookup_key[32:1], source_file_id[64:33], source_line_no[84:65],
	// block_bytes[116:85], zero pad [119:117]
	input  logic [119:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status[2:0], live_entries[12:3], zero pad [15:13]
	output logic [15:0]  m_tdata
);
	lpht_pkg::cmd_t cmd;
	lpht_pkg::sts_t sts;
	logic [2:0] status;
	logic [lpht_pkg::LiveW-1:0] live;

	lpht_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.out_valid(m_tvalid), .out_ready(m_tready), .status(status), .sts(sts), .cmd(cmd)
	);
	lpht_datapath #(.TableBits(TABLE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_word(s_tdata[lpht_pkg::EntryW:0]),
		.cmd(cmd), .sts(sts), .live(live)
	);
	assign m_tdata = {3'b000, live, status};
endmodule

FILE: sv/lpht_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module lpht_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

FILE: sv/lpht_datapath.sv
// Datapath: input capture, slot memory, probe and hole indexes, live count.
// Depends on lpht_pkg and lpht_ram.
`timescale 1ns / 1ps
module lpht_datapath #(
	parameter int TableBits = lpht_pkg::TableBitsDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [lpht_pkg::EntryW:0]     in_word,
	input  lpht_pkg::cmd_t                cmd,
	output lpht_pkg::sts_t                sts,
	output logic [lpht_pkg::LiveW-1:0]    live
);
	localparam int Size = 1 << TableBits;
	localparam logic [TableBits:0] FullMark = (TableBits+1)'(Size - 1);

	logic                       op_q;
	logic [lpht_pkg::EntryW-1:0] ent_q;
	logic [TableBits-1:0]       idx_q, hole_q;
	logic [TableBits:0]         cnt_q;
	logic [TableBits:0]         clr_q;
	logic [TableBits-1:0]       addr;
	logic                       we;
	logic [lpht_pkg::EntryW:0]  wdata, rdata;
	logic [31:0]                rkey;
	logic [TableBits-1:0]       rhome, home_in;
	logic                       shift_ok;

	// slot word: valid at top, then bytes, line, file, key
	assign home_in = TableBits'(lpht_pkg::hash32(in_word[lpht_pkg::KeyW:1]));
	assign rkey = rdata[lpht_pkg::KeyW-1:0];
	assign rhome = TableBits'(lpht_pkg::hash32(rkey));

	always_comb begin
		addr = idx_q;
		we = 1'b0;
		wdata = '0;
		if (cmd.clr_step) begin
			addr = clr_q[TableBits-1:0];
			we = 1'b1;
		end else if (cmd.ins) begin
			we = 1'b1;
			wdata = {1'b1, ent_q};
		end else if (cmd.clr_hole) begin
			addr = hole_q;
			we = 1'b1;
		end else if (cmd.move) begin
			// the walk slot read lands this cycle; copy it into the hole
			addr = hole_q;
			we = 1'b1;
			wdata = rdata;
		end
	end

	lpht_ram #(.Width(lpht_pkg::EntryW + 1), .Depth(Size)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			clr_q <= '0;
			idx_q <= '0;
			hole_q <= '0;
			op_q <= 1'b0;
		end else begin
			if (cmd.clr_step) clr_q <= clr_q + 1'b1;
			if (cmd.load) begin
				op_q <= in_word[0];
				idx_q <= home_in;
			end else if (cmd.start_shift) begin
				hole_q <= idx_q;
				idx_q <= idx_q + 1'b1;
			end else if (cmd.move) begin
				hole_q <= idx_q;
				idx_q <= idx_q + 1'b1;
			end else if (cmd.adv) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.inc) cnt_q <= cnt_q + 1'b1;
			else if (cmd.dec) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) ent_q <= in_word[lpht_pkg::EntryW:1];
	end

	// entry at pos (idx) with home h may fill hole
	always_comb begin
		if (idx_q >= rhome) shift_ok = (hole_q >= rhome) && (idx_q > hole_q);
		else shift_ok = (hole_q >= rhome) || (idx_q > hole_q);
	end
	assign sts.may_shift = shift_ok;
	assign sts.slot_valid = rdata[lpht_pkg::EntryW];
	assign sts.key_match = rkey == ent_q[lpht_pkg::KeyW-1:0];
	assign sts.zero_key = ent_q[lpht_pkg::KeyW-1:0] == '0;
	assign sts.is_remove = op_q;
	assign sts.full = cnt_q >= FullMark;
	assign sts.clr_done = clr_q[TableBits];
	assign live = lpht_pkg::LiveW'(cnt_q);
endmodule

FILE: sv/lpht_ctrl.sv
// Controller state machine: clearing sweep, probe, insert, remove and shift-back.
// Depends on lpht_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lpht_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          status,
	input  lpht_pkg::sts_t      sts,
	output lpht_pkg::cmd_t      cmd
);
	lpht_pkg::state_t state_q, state_d;
	lpht_pkg::status_t st_q, st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpht_pkg::S_CLEAR;
			st_q <= lpht_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			st_q <= st_d;
		end
	end

	always_comb begin
		state_d = state_q;
		st_d = st_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			lpht_pkg::S_CLEAR: begin
				if (sts.clr_done) state_d = lpht_pkg::S_IDLE;
				else cmd.clr_step = 1'b1;
			end
			lpht_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = lpht_pkg::S_PRD;
				end
			end
			lpht_pkg::S_PRD: begin
				if (sts.zero_key) begin
					st_d = lpht_pkg::ST_ZERO;
					state_d = lpht_pkg::S_DONE;
				end else if (!sts.is_remove && sts.full) begin
					st_d = lpht_pkg::ST_FULL;
					state_d = lpht_pkg::S_DONE;
				end else begin
					cmd.rd = 1'b1;
					state_d = lpht_pkg::S_PCHK;
				end
			end
			lpht_pkg::S_PCHK: begin
				if (!sts.slot_valid) begin
					if (sts.is_remove) begin
						st_d = lpht_pkg::ST_MISSING;
					end else begin
						st_d = lpht_pkg::ST_OK;
						cmd.ins = 1'b1;
						cmd.inc = 1'b1;
					end
					state_d = lpht_pkg::S_DONE;
				end else if (sts.key_match) begin
					if (sts.is_remove) begin
						st_d = lpht_pkg::ST_OK;
						cmd.start_shift = 1'b1;
						cmd.dec = 1'b1;
						state_d = lpht_pkg::S_SRD;
					end else begin
						st_d = lpht_pkg::ST_DUP;
						state_d = lpht_pkg::S_DONE;
					end
				end else begin
					cmd.adv = 1'b1;
					state_d = lpht_pkg::S_PRD;
				end
			end
			lpht_pkg::S_SRD: begin
				// hole register now holds the removed slot or the slot just moved out of
				cmd.clr_hole = 1'b1;
				state_d = lpht_pkg::S_SCHK;
			end
			lpht_pkg::S_SCHK: begin
				// the walk slot is read in this state; its data is checked in S_SMOVE
				state_d = lpht_pkg::S_SMOVE;
			end
			lpht_pkg::S_SMOVE: begin
				if (!sts.slot_valid) begin
					state_d = lpht_pkg::S_DONE;
				end else if (sts.may_shift) begin
					cmd.move = 1'b1;
					state_d = lpht_pkg::S_SRD;
				end else begin
					cmd.adv = 1'b1;
					state_d = lpht_pkg::S_SCHK;
				end
			end
			lpht_pkg::S_DONE: begin
				out_valid = 1'b1;
				if (out_ready) state_d = lpht_pkg::S_IDLE;
			end
			default: state_d = lpht_pkg::S_CLEAR;
		endcase
	end
	assign status = st_q;

	`ASSERT_WHEN(a_ins_empty, clk, arst_n, cmd.ins, sts.slot_valid == 1'b0, "insert over live slot")
	`ASSERT_WHEN(a_move_valid, clk, arst_n, cmd.move, sts.slot_valid, "move of empty slot")
	`ASSERT_IMPL(a_no_both, clk, arst_n, !(in_ready && out_valid), "accept while result waits")
endmodule
